// ===== rtl/sqgrt_pkg.sv =====
// Package for the square character grid rotate/transpose unit.
// Holds request/response payload types, the phase type and fixed character codes.
// No dependencies.
`timescale 1ns / 1ps

package sqgrt_pkg;

  // Command codes carried by a request.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  // Transform mode codes of the configuration register (code 3 acts as anti-transpose).
  localparam logic [1:0] MODE_ANTI = 2'd0;
  localparam logic [1:0] MODE_ROT  = 2'd1;
  localparam logic [1:0] MODE_SIDE = 2'd2;

  // Fixed characters.
  localparam logic [7:0] CHAR_NL  = 8'd10;
  localparam logic [7:0] CHAR_BAR = 8'd124;
  localparam logic [7:0] CHAR_NUL = 8'd0;

  // Phase of the unit.
  typedef enum logic [1:0] {
    PH_LOADING  = 2'd0,
    PH_EMITTING = 2'd1,
    PH_DONE     = 2'd2
  } phase_e;

  // Input request payload.
  typedef struct packed {
    logic       cmd;
    logic [7:0] in_char;
    logic       final_byte;
  } in_req_t;

  // Output response payload.
  typedef struct packed {
    logic [7:0] out_char;
    logic       is_last;
    logic       out_valid;
    logic       size_overflow;
  } out_rsp_t;

  // Source selection for one output byte: from the grid store or a literal.
  typedef struct packed {
    logic       use_mem;
    logic [7:0] lit;
  } pick_t;

endpackage

// ===== rtl/sqgrt_pick.sv =====
// Address generator: maps an output row/column to a grid store address or a separator.
// Also gives the row length of the current mode. Depends on sqgrt_pkg.
`timescale 1ns / 1ps

module sqgrt_pick #(
  parameter int MAX_SIDE = 16
) (
  input  logic [1:0]                    mode_i,
  input  logic [$clog2(MAX_SIDE+1)-1:0] side_i,
  input  logic [((MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1)-1:0] row_i,
  input  logic [$clog2(3*MAX_SIDE+3)-1:0] col_i,
  output logic [$clog2(3*MAX_SIDE+3)-1:0] len_o,
  output sqgrt_pkg::pick_t                pick_o,
  output logic [((MAX_SIDE > 1) ? $clog2(MAX_SIDE*MAX_SIDE) : 1)-1:0] addr_o
);

  localparam int SW    = $clog2(MAX_SIDE+1);
  localparam int IdxW  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CW    = $clog2(3*MAX_SIDE+3);
  localparam int AddrW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE*MAX_SIDE) : 1;

  logic [CW-1:0]   n_x;
  logic [CW-1:0]   n2_x;
  logic [SW-1:0]   nm1r;
  logic [IdxW-1:0] src_r;
  logic [IdxW-1:0] src_c;

  assign n_x  = CW'(side_i);
  assign n2_x = CW'(n_x + n_x);
  assign nm1r = SW'(side_i - SW'(1) - SW'(row_i));

  // Row length: three segments plus two separators in side-by-side mode.
  assign len_o = (mode_i == sqgrt_pkg::MODE_SIDE) ? CW'(n2_x + n_x + CW'(2)) : n_x;

  // Pick the source position of the byte at (row, col).
  always_comb begin
    logic [CW-1:0] cp;
    logic [CW-1:0] nm1c;
    cp          = col_i;
    pick_o.use_mem = 1'b1;
    pick_o.lit  = sqgrt_pkg::CHAR_NUL;
    src_r       = '0;
    src_c       = '0;
    nm1c        = '0;
    if (mode_i == sqgrt_pkg::MODE_ROT) begin
      src_r = IdxW'(cp);
      src_c = IdxW'(nm1r);
    end else if (mode_i != sqgrt_pkg::MODE_SIDE) begin
      nm1c  = CW'(n_x - CW'(1) - cp);
      src_r = IdxW'(nm1c);
      src_c = IdxW'(nm1r);
    end else if (col_i < n_x) begin
      // Original row.
      src_r = row_i;
      src_c = IdxW'(cp);
    end else if (col_i == n_x || col_i == CW'(n2_x + CW'(1))) begin
      pick_o.use_mem = 1'b0;
      pick_o.lit     = sqgrt_pkg::CHAR_BAR;
    end else if (col_i < CW'(n2_x + CW'(1))) begin
      // Anti-transposed segment.
      cp    = CW'(col_i - n_x - CW'(1));
      nm1c  = CW'(n_x - CW'(1) - cp);
      src_r = IdxW'(nm1c);
      src_c = IdxW'(nm1r);
    end else begin
      // Rotated segment.
      cp    = CW'(col_i - n2_x - CW'(2));
      src_r = IdxW'(cp);
      src_c = IdxW'(nm1r);
    end
  end

  assign addr_o = AddrW'(AddrW'(src_r) * AddrW'(MAX_SIDE) + AddrW'(src_c));

endmodule

// ===== rtl/square_char_grid_rotate_transpose_unit.sv =====
// Top level of the square character grid rotate/transpose unit.
// Uses sqgrt_pkg and the address generator sqgrt_pick; holds the grid store.
`timescale 1ns / 1ps

// Usage:
// Requests enter on the in channel (valid/ready, payload in_req_i). A load request
// writes one byte of the grid text; newline separates rows and final_byte ends the
// grid. Each pull request returns exactly one response on the out channel
// (valid/ready, payload out_rsp_o): the next byte of the transformed text, or an
// invalid byte (out_valid clear) when no text is available. Loads give no response.
// The transform mode is written through cfg_we_i/cfg_wdata_i; the user must do so
// only while the unit is idle, as the unit does not enforce it. Throughput is one
// request per cycle while the out channel does not stall. A pull reads the grid store
// into the read stage, which then loads the output register once that is free.
// The side is set by the first row, up to MAX_SIDE.
// Reset clears all counters and the mode and returns to loading; the grid store is
// not cleared and holds stale bytes. When the receiver stalls, the output register
// and the read stage fill and in_ready_o drops until the response is taken.
module square_char_grid_rotate_transpose_unit #(
  parameter int MAX_SIDE = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sqgrt_pkg::in_req_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sqgrt_pkg::out_rsp_t out_rsp_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i
);

  localparam int SW    = $clog2(MAX_SIDE+1);
  localparam int IdxW  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int LcW   = $clog2(MAX_SIDE+2);
  localparam int CW    = $clog2(3*MAX_SIDE+3);
  localparam int AddrW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE*MAX_SIDE) : 1;
  localparam int Depth = MAX_SIDE * MAX_SIDE;

  // State registers.
  sqgrt_pkg::phase_e phase_q, phase_d;
  logic [SW-1:0]     side_q, side_d;
  logic [SW-1:0]     load_row_q, load_row_d;
  logic [LcW-1:0]    load_col_q, load_col_d;
  logic [IdxW-1:0]   emit_row_q, emit_row_d;
  logic [CW-1:0]     emit_col_q, emit_col_d;
  logic              ovf_q, ovf_d;
  logic [1:0]        mode_q;

  // Read stage and output register.
  logic              s1_v_q, s1_v_d;
  sqgrt_pkg::pick_t  s1_pick_q, s1_pick_d;
  logic              s1_last_q, s1_last_d;
  logic              s1_ok_q, s1_ok_d;
  logic              s1_ovf_q, s1_ovf_d;
  logic              out_v_q;
  sqgrt_pkg::out_rsp_t out_rsp_q;
  logic [7:0]        rdata_q;

  // Grid store.
  logic [7:0]        mem_q [Depth];
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic              mem_re;

  logic              in_acc;
  logic              out_free;
  logic              s1_move;

  logic [CW-1:0]     len;
  sqgrt_pkg::pick_t  pick;
  logic [AddrW-1:0]  pick_addr;

  // Handshake.
  assign out_free   = !out_v_q || out_ready_i;
  assign s1_move    = s1_v_q && out_free;
  assign in_ready_o = !s1_v_q || out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  sqgrt_pick #(
    .MAX_SIDE(MAX_SIDE)
  ) u_pick (
    .mode_i (mode_q),
    .side_i (side_q),
    .row_i  (emit_row_q),
    .col_i  (emit_col_q),
    .len_o  (len),
    .pick_o (pick),
    .addr_o (pick_addr)
  );

  // Next state of the loader and emitter for one accepted request.
  always_comb begin
    logic last_row;
    phase_d    = phase_q;
    side_d     = side_q;
    load_row_d = load_row_q;
    load_col_d = load_col_q;
    emit_row_d = emit_row_q;
    emit_col_d = emit_col_q;
    ovf_d      = ovf_q;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_re     = 1'b0;
    s1_pick_d  = '{use_mem: 1'b0, lit: sqgrt_pkg::CHAR_NUL};
    s1_last_d  = 1'b0;
    s1_ok_d    = 1'b0;
    s1_ovf_d   = ovf_q;
    last_row   = (SW'(emit_row_q) + SW'(1)) >= side_q;
    if (in_acc && in_req_i.cmd == sqgrt_pkg::CMD_LOAD) begin
      // A load after loading has ended starts a new grid.
      if (phase_q != sqgrt_pkg::PH_LOADING) begin
        side_d     = '0;
        load_row_d = '0;
        load_col_d = '0;
        ovf_d      = 1'b0;
        phase_d    = sqgrt_pkg::PH_LOADING;
      end
      if (in_req_i.in_char == sqgrt_pkg::CHAR_NL) begin
        if (load_col_d != '0) begin
          if (load_row_d == '0) begin
            side_d = (load_col_d > LcW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(load_col_d);
          end
          if (load_row_d < SW'(MAX_SIDE)) begin
            load_row_d = SW'(load_row_d + SW'(1));
          end
          load_col_d = '0;
        end
      end else begin
        if (load_row_d < SW'(MAX_SIDE) && load_col_d < LcW'(MAX_SIDE)) begin
          mem_we    = 1'b1;
          mem_waddr = AddrW'(AddrW'(load_row_d[IdxW-1:0]) * AddrW'(MAX_SIDE)
                      + AddrW'(load_col_d[IdxW-1:0]));
        end else begin
          ovf_d = 1'b1;
        end
        if (load_col_d <= LcW'(MAX_SIDE)) begin
          load_col_d = LcW'(load_col_d + LcW'(1));
        end
      end
      if (in_req_i.final_byte) begin
        if (load_row_d == '0) begin
          side_d = (load_col_d > LcW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(load_col_d);
        end
        emit_row_d = '0;
        emit_col_d = '0;
        phase_d    = (side_d == '0) ? sqgrt_pkg::PH_DONE : sqgrt_pkg::PH_EMITTING;
      end
    end else if (in_acc && phase_q == sqgrt_pkg::PH_EMITTING) begin
      if (emit_col_q >= len) begin
        // End of row: newline, or end of text on the last row.
        if (last_row) begin
          phase_d = sqgrt_pkg::PH_DONE;
        end else begin
          s1_ok_d        = 1'b1;
          s1_pick_d.lit  = sqgrt_pkg::CHAR_NL;
          emit_row_d     = IdxW'(emit_row_q + IdxW'(1));
          emit_col_d     = '0;
        end
      end else begin
        s1_ok_d   = 1'b1;
        s1_pick_d = pick;
        mem_re    = pick.use_mem;
        if (last_row && CW'(emit_col_q + CW'(1)) == len) begin
          s1_last_d = 1'b1;
          phase_d   = sqgrt_pkg::PH_DONE;
        end
        emit_col_d = CW'(emit_col_q + CW'(1));
      end
    end
  end

  // Read stage occupancy.
  always_comb begin
    s1_v_d = s1_v_q;
    if (in_acc && in_req_i.cmd == sqgrt_pkg::CMD_PULL) begin
      s1_v_d = 1'b1;
    end else if (s1_move) begin
      s1_v_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= sqgrt_pkg::PH_LOADING;
      side_q     <= '0;
      load_row_q <= '0;
      load_col_q <= '0;
      emit_row_q <= '0;
      emit_col_q <= '0;
      ovf_q      <= 1'b0;
      mode_q     <= sqgrt_pkg::MODE_ANTI;
      s1_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      side_q     <= side_d;
      load_row_q <= load_row_d;
      load_col_q <= load_col_d;
      emit_row_q <= emit_row_d;
      emit_col_q <= emit_col_d;
      ovf_q      <= ovf_d;
      s1_v_q     <= s1_v_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (s1_move) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload of the read stage; captured with each accepted pull.
  always_ff @(posedge clk_i) begin
    if (in_acc && in_req_i.cmd == sqgrt_pkg::CMD_PULL) begin
      s1_pick_q <= s1_pick_d;
      s1_last_q <= s1_last_d;
      s1_ok_q   <= s1_ok_d;
      s1_ovf_q  <= s1_ovf_d;
    end
  end

  // Grid store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= in_req_i.in_char;
    end
    if (mem_re) begin
      rdata_q <= mem_q[pick_addr];
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_rsp_q.out_char      <= s1_pick_q.use_mem ? rdata_q : s1_pick_q.lit;
      out_rsp_q.is_last       <= s1_last_q;
      out_rsp_q.out_valid     <= s1_ok_q;
      out_rsp_q.size_overflow <= s1_ovf_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
